// File: rtl/midpoint_ellipse_point_generator_unit_assert.svh
// assertion macros for the midpoint ellipse point generator
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef MIDPOINT_ELLIPSE_POINT_GENERATOR_UNIT_ASSERT_SVH
`define MIDPOINT_ELLIPSE_POINT_GENERATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication under an active-low reset
`define MEG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication under an active-low reset
`define MEG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MEG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MEG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/meg_pkg.sv
// shared types and constants for the midpoint ellipse point generator
// no dependencies
`default_nettype none
package meg_pkg;

	localparam int RADIUS_BITS_DEF = 5;
	localparam int PT_W = 5;
	localparam int SEL_W = 2;

	localparam logic [SEL_W-1:0] SEL_BOTH = 2'd0;
	localparam logic [SEL_W-1:0] SEL_TOP  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_SIDE = 2'd2;

	localparam logic REGION_TOP  = 1'b0;
	localparam logic REGION_SIDE = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		logic [PT_W-1:0]  semi_width;
		logic [PT_W-1:0]  semi_height;
		logic [SEL_W-1:0] piece_select;
	} request_t;

	typedef struct packed {
		logic [PT_W-1:0] point_x;
		logic [PT_W-1:0] point_y;
		logic            region;
		logic            last_point;
	} result_t;

	// point handed from the sequencer to the output stage
	typedef struct packed {
		logic            push;
		logic            flush;
		logic [PT_W-1:0] x;
		logic [PT_W-1:0] y;
		logic            region;
	} emit_req_t;

endpackage
`default_nettype wire

// File: rtl/meg_alu.sv
// shared arithmetic unit: add, subtract and a small unsigned multiply
// depends on meg_pkg
`default_nettype none
module meg_alu import meg_pkg::*; #(
	parameter int W    = 23,
	parameter int MA_W = 10,
	parameter int MB_W = 6
) (
	input  alu_op_t             op,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] y
);

	logic [MA_W+MB_W-1:0] prod;

	// multiply on the low operand bits only
	always_comb begin
		prod = a[MA_W-1:0] * b[MB_W-1:0];
	end

	// operation select
	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			ALU_MUL: y = signed'(W'(prod));
			default: y = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/meg_emit.sv
// output stage: holds one point back so that the final beat carries last_point
// depends on meg_pkg
`default_nettype none
module meg_emit import meg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  emit_req_t req,
	output logic      strobe,
	output result_t   result
);

	logic    pend_v_q;
	logic    strobe_q;
	result_t pend_q;
	result_t res_q;

	// control: pending flag and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (req.push || req.flush) && pend_v_q;
			if (req.push) begin
				pend_v_q <= 1'b1;
			end else if (req.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// payload: pending point and output beat
	always_ff @(posedge clk) begin
		if (req.push) begin
			res_q             <= pend_q;
			pend_q.point_x    <= req.x;
			pend_q.point_y    <= req.y;
			pend_q.region     <= req.region;
			pend_q.last_point <= 1'b0;
		end else if (req.flush) begin
			res_q <= '{point_x: pend_q.point_x, point_y: pend_q.point_y,
			           region: pend_q.region, last_point: 1'b1};
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule
`default_nettype wire

// File: rtl/meg_seq.sv
// sequencer and working registers of the two-region midpoint walk
// depends on meg_pkg; drives the shared unit in meg_alu
`default_nettype none
module meg_seq import meg_pkg::*; #(
	parameter int R = RADIUS_BITS_DEF,
	parameter int W = 3 * RADIUS_BITS_DEF + 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  request_t            request,
	output alu_op_t             alu_op,
	output logic signed [W-1:0] alu_a,
	output logic signed [W-1:0] alu_b,
	input  logic signed [W-1:0] alu_y,
	output emit_req_t           emit
);

	localparam int XY_W = R + 2;
	localparam int SQ_W = 2 * R;
	localparam int K6_W = 2 * R + 3;
	localparam logic signed [XY_W-1:0] XY_ONE = XY_W'(1);
	localparam logic signed [W-1:0]    SIX    = W'(3'd6);

	typedef enum logic [4:0] {
		ST_IDLE, ST_A2, ST_B2, ST_K6A, ST_K6B,
		ST_T0, ST_T1, ST_T2, ST_TC,
		ST_TY1, ST_TY2, ST_TY3, ST_TX1, ST_TX2, ST_TX3,
		ST_S0, ST_S1, ST_S2, ST_SC,
		ST_SD1, ST_SD2, ST_SD3, ST_SI1, ST_SI2, ST_SI3,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   busy_q;

	logic [R-1:0]           w_q, h_q;
	logic                   want_top_q, want_side_q;
	logic [SQ_W-1:0]        a2_q, b2_q;
	logic [K6_W-1:0]        k6a_q, k6b_q;
	logic signed [W-1:0]    bx_q, ay_q, sig_q;
	logic signed [XY_W-1:0] x_q, y_q;

	logic [R-1:0]        w_in, h_in;
	logic                accept;
	logic                neg;
	logic signed [W-1:0] a2_x, b2_x, w_x, h_x, k6a_x, k6b_x;

	assign accept = start && !busy_q;
	assign neg    = alu_y[W-1];

	// radii cut to R bits, zero saturated to one
	assign w_in = (request.semi_width[R-1:0] == '0) ? R'(1) : request.semi_width[R-1:0];
	assign h_in = (request.semi_height[R-1:0] == '0) ? R'(1) : request.semi_height[R-1:0];

	// operand views at accumulator width
	assign a2_x  = signed'(W'(a2_q));
	assign b2_x  = signed'(W'(b2_q));
	assign w_x   = signed'(W'(w_q));
	assign h_x   = signed'(W'(h_q));
	assign k6a_x = signed'(W'(k6a_q));
	assign k6b_x = signed'(W'(k6b_q));

	// shared unit operands per step
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			ST_A2:  begin alu_op = ALU_MUL; alu_a = w_x;  alu_b = w_x; end
			ST_B2:  begin alu_op = ALU_MUL; alu_a = h_x;  alu_b = h_x; end
			ST_K6A: begin alu_op = ALU_MUL; alu_a = a2_x; alu_b = SIX; end
			ST_K6B: begin alu_op = ALU_MUL; alu_a = b2_x; alu_b = SIX; end
			ST_T0:  begin alu_op = ALU_MUL; alu_a = a2_x; alu_b = h_x; end
			ST_T1:  begin alu_op = ALU_ADD; alu_a = b2_x <<< 1; alu_b = a2_x; end
			ST_T2:  begin alu_op = ALU_SUB; alu_a = sig_q; alu_b = ay_q <<< 1; end
			ST_TC:  begin alu_op = ALU_SUB; alu_a = ay_q;  alu_b = bx_q; end
			ST_TY1: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = a2_x <<< 2; end
			ST_TY2: begin alu_op = ALU_SUB; alu_a = sig_q; alu_b = ay_q <<< 2; end
			ST_TY3: begin alu_op = ALU_SUB; alu_a = ay_q;  alu_b = a2_x; end
			ST_TX1: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = bx_q <<< 2; end
			ST_TX2: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = k6b_x; end
			ST_TX3: begin alu_op = ALU_ADD; alu_a = bx_q;  alu_b = b2_x; end
			ST_S0:  begin alu_op = ALU_MUL; alu_a = b2_x; alu_b = w_x; end
			ST_S1:  begin alu_op = ALU_ADD; alu_a = a2_x <<< 1; alu_b = b2_x; end
			ST_S2:  begin alu_op = ALU_SUB; alu_a = sig_q; alu_b = bx_q <<< 1; end
			ST_SC:  begin alu_op = ALU_SUB; alu_a = bx_q;  alu_b = ay_q; end
			ST_SD1: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = b2_x <<< 2; end
			ST_SD2: begin alu_op = ALU_SUB; alu_a = sig_q; alu_b = bx_q <<< 2; end
			ST_SD3: begin alu_op = ALU_SUB; alu_a = bx_q;  alu_b = b2_x; end
			ST_SI1: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = ay_q <<< 2; end
			ST_SI2: begin alu_op = ALU_ADD; alu_a = sig_q; alu_b = k6a_x; end
			ST_SI3: begin alu_op = ALU_ADD; alu_a = ay_q;  alu_b = a2_x; end
			default: begin alu_op = ALU_ADD; alu_a = '0; alu_b = '0; end
		endcase
	end

	// point hand-off on a passing region test, flush once both walks end
	always_comb begin
		emit.push   = 1'b0;
		emit.flush  = (state_q == ST_FLUSH);
		emit.x      = PT_W'(x_q[R-1:0]);
		emit.y      = PT_W'(y_q[R-1:0]);
		emit.region = REGION_TOP;
		if (state_q == ST_TC) begin
			emit.push = !neg && want_top_q;
		end else if (state_q == ST_SC) begin
			emit.push   = !neg && want_side_q;
			emit.region = REGION_SIDE;
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_A2;
						busy_q  <= 1'b1;
					end
				end
				ST_A2:  state_q <= ST_B2;
				ST_B2:  state_q <= ST_K6A;
				ST_K6A: state_q <= ST_K6B;
				ST_K6B: state_q <= ST_T0;
				ST_T0:  state_q <= ST_T1;
				ST_T1:  state_q <= ST_T2;
				ST_T2:  state_q <= ST_TC;
				ST_TC: begin
					if (neg) begin
						state_q <= ST_S0;
					end else if (!sig_q[W-1]) begin
						state_q <= ST_TY1;
					end else begin
						state_q <= ST_TX1;
					end
				end
				ST_TY1: state_q <= ST_TY2;
				ST_TY2: state_q <= ST_TY3;
				ST_TY3: state_q <= ST_TX1;
				ST_TX1: state_q <= ST_TX2;
				ST_TX2: state_q <= ST_TX3;
				ST_TX3: state_q <= ST_TC;
				ST_S0:  state_q <= ST_S1;
				ST_S1:  state_q <= ST_S2;
				ST_S2:  state_q <= ST_SC;
				ST_SC: begin
					if (neg) begin
						state_q <= ST_FLUSH;
					end else if (!sig_q[W-1]) begin
						state_q <= ST_SD1;
					end else begin
						state_q <= ST_SI1;
					end
				end
				ST_SD1: state_q <= ST_SD2;
				ST_SD2: state_q <= ST_SD3;
				ST_SD3: state_q <= ST_SI1;
				ST_SI1: state_q <= ST_SI2;
				ST_SI2: state_q <= ST_SI3;
				ST_SI3: state_q <= ST_SC;
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					w_q         <= w_in;
					h_q         <= h_in;
					want_top_q  <= (request.piece_select == SEL_BOTH) ||
					               (request.piece_select == SEL_TOP);
					want_side_q <= (request.piece_select == SEL_BOTH) ||
					               (request.piece_select == SEL_SIDE);
				end
			end
			ST_A2:  a2_q  <= alu_y[SQ_W-1:0];
			ST_B2:  b2_q  <= alu_y[SQ_W-1:0];
			ST_K6A: k6a_q <= alu_y[K6_W-1:0];
			ST_K6B: k6b_q <= alu_y[K6_W-1:0];
			ST_T0: begin
				ay_q <= alu_y;
				bx_q <= '0;
				x_q  <= '0;
				y_q  <= signed'(XY_W'(h_q));
			end
			ST_T1, ST_T2, ST_TY1, ST_TY2, ST_TX1, ST_TX2,
			ST_S1, ST_S2, ST_SD1, ST_SD2, ST_SI1, ST_SI2: sig_q <= alu_y;
			ST_TY3: begin
				ay_q <= alu_y;
				y_q  <= y_q - XY_ONE;
			end
			ST_TX3: begin
				bx_q <= alu_y;
				x_q  <= x_q + XY_ONE;
			end
			ST_S0: begin
				bx_q <= alu_y;
				ay_q <= '0;
				x_q  <= signed'(XY_W'(w_q));
				y_q  <= '0;
			end
			ST_SD3: begin
				bx_q <= alu_y;
				x_q  <= x_q - XY_ONE;
			end
			ST_SI3: begin
				ay_q <= alu_y;
				y_q  <= y_q + XY_ONE;
			end
			default: ;
		endcase
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// File: rtl/midpoint_ellipse_point_generator_unit.sv
// Midpoint ellipse point generator: one request, then a walk of both regions.
// Setup forms both squared radii and six times each; then each region is entered and walked until its exit
// test fails, then a flush; a walked point always steps one coordinate and sometimes the second, on one shared unit.
// Busy is high from an accepted request until the flush.
// Beats are never stalled; the last one shows as busy falls.
// Reset clears the sequencer and the output strobe; the data registers are not reset.
`default_nettype none
`include "midpoint_ellipse_point_generator_unit_assert.svh"
module midpoint_ellipse_point_generator_unit import meg_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     strobe,
	output result_t  result
);

	localparam int W    = 3 * RADIUS_BITS + 8;
	localparam int MA_W = 2 * RADIUS_BITS;
	localparam int MB_W = RADIUS_BITS + 1;

	alu_op_t             alu_op;
	logic signed [W-1:0] alu_a, alu_b, alu_y;
	emit_req_t           emit;

	// sequencer
	meg_seq #(
		.R (RADIUS_BITS),
		.W (W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.alu_op  (alu_op),
		.alu_a   (alu_a),
		.alu_b   (alu_b),
		.alu_y   (alu_y),
		.emit    (emit)
	);

	// shared arithmetic
	meg_alu #(
		.W    (W),
		.MA_W (MA_W),
		.MB_W (MB_W)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// output beat with last marking
	meg_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (emit),
		.strobe (strobe),
		.result (result)
	);

	// checks
	`MEG_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`MEG_ASSERT_IMP(a_strobe_in_req, clk, arst_n, strobe, $past(busy), "result beat outside a request")
	`MEG_ASSERT_NXT(a_last_alone, clk, arst_n, strobe && result.last_point, !strobe, "beat after last")

endmodule
`default_nettype wire
